### rtl/apqs_pkg.sv
// shared constants for the aging priority queue scheduler
package apqs_pkg;

  // default sizes
  localparam int NUM_QUEUES_DEF = 4;
  localparam int FIFO_DEPTH_DEF = 64;

  // field widths
  localparam int MODE_W   = 2;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 3;
  localparam int WAIT_W   = 32;
  localparam int THR_W    = 16;
  localparam int PRIO_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W   = WAIT_W + THR_W;

  // transaction modes
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_PRIO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POST_PRIO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 2'd3;

endpackage

### rtl/aging_priority_queue_scheduler.sv
// aging priority scheduler for one output port: stamp fifos, sequencer and shared multiplier
//
// Input channel (in_valid/in_ready, mode, queue_id) takes one transaction at a time:
// insert stamps the service counter into a queue's fifo, drop removes the newest
// stamp, request picks the queue to serve and pops its head stamp.
// Output channel (out_valid/out_ready, status, granted_queue, waited) gives one
// result per transaction, held in an output register until taken.
// Configuration port (cfg_wen, cfg_index, cfg_data) writes thresholds, pre and
// post priorities and the active mask; write only while idle.
// Insert, drop and other modes are executed after accept and their result then
// goes to the output register. A request scans the queues one after another: a
// queue that is not eligible takes only the scan step, one that is eligible is
// loaded and decided, and when its priority ties the current best the wait
// ratios go through the shared 32x16 multiplier twice and are compared. After
// the scan the head stamp of the chosen queue, if any, is popped and the result
// is loaded. A new transaction is taken only once the last one is through; it is
// accepted while the last result still waits, but the sequencer halts before
// loading its result until the receiver takes the older one.
// Reset (rst, synchronous) clears counter, fifo pointers, counts, configuration registers
// and out_valid; the stamp memory is not cleared and needs no clearing pass.
module aging_priority_queue_scheduler #(
  parameter int NUM_QUEUES = apqs_pkg::NUM_QUEUES_DEF,
  parameter int FIFO_DEPTH = apqs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [apqs_pkg::MODE_W-1:0]          mode,
  input  logic [apqs_pkg::QID_W-1:0]           queue_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [apqs_pkg::STATUS_W-1:0]        status,
  output logic [apqs_pkg::QID_W-1:0]           granted_queue,
  output logic [apqs_pkg::WAIT_W-1:0]          waited,
  input  logic                                 cfg_wen,
  input  logic [apqs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apqs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int QW    = $clog2(NUM_QUEUES);
  localparam int HW    = $clog2(FIFO_DEPTH);
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam int SW    = $clog2(2 * FIFO_DEPTH);
  localparam int AW    = $clog2(NUM_QUEUES * FIFO_DEPTH);
  localparam int NSCAN = (NUM_QUEUES < 4) ? NUM_QUEUES : 4;
  localparam int WW    = apqs_pkg::WAIT_W;
  localparam int TW    = apqs_pkg::THR_W;
  localparam int PW    = apqs_pkg::PRIO_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_LOAD, S_DECIDE, S_MULA, S_MULB, S_CMP, S_DONE, S_RESP
  } state_t;

  state_t state;

  // configuration registers
  logic [4*TW-1:0] thr_cfg;
  logic [4*PW-1:0] pre_cfg;
  logic [4*PW-1:0] post_cfg;
  logic [3:0]      act_cfg;

  // queue bookkeeping
  logic [WW-1:0] svc_count;
  logic [HW-1:0] head [NUM_QUEUES];
  logic [CW-1:0] cnt  [NUM_QUEUES];

  // latched transaction
  logic [apqs_pkg::MODE_W-1:0] mode_r;
  logic [apqs_pkg::QID_W-1:0]  q_r;

  // scan and best-so-far
  logic [QW-1:0] scan;
  logic          found;
  logic [QW-1:0] best_q;
  logic [PW-1:0] best_p;
  logic [WW-1:0] best_w;
  logic [TW-1:0] best_t;
  logic [WW-1:0] cur_w;
  logic [PW-1:0] cur_p;
  logic [TW-1:0] cur_t;
  logic [apqs_pkg::PROD_W-1:0] prod_a;
  logic [apqs_pkg::PROD_W-1:0] prod_b;

  // pending result
  logic [apqs_pkg::STATUS_W-1:0] res_status;
  logic [apqs_pkg::QID_W-1:0]    res_q;
  logic [WW-1:0]                 res_w;

  // stamp memory
  logic [WW-1:0] mem [NUM_QUEUES * FIFO_DEPTH];
  logic [WW-1:0] rdata;

  logic [QW-1:0] sel_q;
  logic          q_ok;
  logic          ins_ok;
  logic          drop_ok;
  logic [SW-1:0] pos_sum;
  logic [HW-1:0] wr_off;
  logic [AW-1:0] base;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [1:0]    sq2;
  logic          elig;
  logic [TW-1:0] thr_s;
  logic [PW-1:0] pre_s;
  logic [PW-1:0] post_s;
  logic [WW-1:0] w_s;
  logic          scan_last;
  logic [WW-1:0] mul_x;
  logic [TW-1:0] mul_y;
  logic [apqs_pkg::PROD_W-1:0] mul_out;
  logic [HW-1:0] head_inc;

  assign in_ready = (state == S_IDLE);

  // queue selection for bookkeeping and memory address
  assign sel_q   = (state == S_SCAN) ? scan : QW'(q_r);
  assign q_ok    = (32'(q_r) < NUM_QUEUES);
  assign ins_ok  = q_ok && (cnt[sel_q] < CW'(FIFO_DEPTH));
  assign drop_ok = q_ok && (cnt[sel_q] != '0);

  // tail position with wrap
  always_comb begin
    pos_sum = SW'(head[sel_q]) + SW'(cnt[sel_q]);
    if (pos_sum >= SW'(FIFO_DEPTH)) begin
      wr_off = HW'(pos_sum - SW'(FIFO_DEPTH));
    end else begin
      wr_off = HW'(pos_sum);
    end
  end

  assign base    = AW'(AW'(sel_q) * AW'(FIFO_DEPTH));
  assign wr_addr = base + AW'(wr_off);
  assign rd_addr = base + AW'(head[sel_q]);
  assign mem_we  = (state == S_EXEC) && (mode_r == apqs_pkg::MODE_INSERT) && ins_ok;

  // stamp memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= svc_count;
    end
    rdata <= mem[rd_addr];
  end

  // per-queue configuration of the scanned queue
  assign sq2    = 2'(scan);
  assign thr_s  = thr_cfg[TW*sq2 +: TW];
  assign pre_s  = pre_cfg[PW*sq2 +: PW];
  assign post_s = (post_cfg[PW*sq2 +: PW] < pre_s) ? pre_s : post_cfg[PW*sq2 +: PW];
  assign elig   = act_cfg[sq2] && (cnt[scan] != '0);
  assign w_s    = svc_count - rdata;
  assign scan_last = (scan == QW'(NSCAN - 1));

  // shared multiplier for the ratio cross products
  assign mul_x   = (state == S_MULA) ? cur_w : best_w;
  assign mul_y   = (state == S_MULA) ? best_t : cur_t;
  assign mul_out = apqs_pkg::PROD_W'(mul_x) * apqs_pkg::PROD_W'(mul_y);

  assign head_inc = (head[best_q] == HW'(FIFO_DEPTH - 1)) ? '0 : head[best_q] + HW'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_cfg  <= '0;
      pre_cfg  <= '0;
      post_cfg <= '0;
      act_cfg  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        apqs_pkg::REG_THRESHOLDS: thr_cfg  <= cfg_data[4*TW-1:0];
        apqs_pkg::REG_PRE_PRIO:   pre_cfg  <= cfg_data[4*PW-1:0];
        apqs_pkg::REG_POST_PRIO:  post_cfg <= cfg_data[4*PW-1:0];
        apqs_pkg::REG_ACTIVE:     act_cfg  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer, bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      svc_count <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      scan      <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      // result taken; the response state reloads it on its own
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            q_r    <= queue_id;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q <= '0;
          res_w <= '0;
          unique case (mode_r)
            apqs_pkg::MODE_INSERT: begin
              state <= S_RESP;
              if (ins_ok) begin
                cnt[sel_q] <= cnt[sel_q] + CW'(1);
                res_status <= apqs_pkg::ST_INSERTED;
              end else begin
                res_status <= apqs_pkg::ST_FULL;
              end
            end
            apqs_pkg::MODE_DROP: begin
              state <= S_RESP;
              if (drop_ok) begin
                cnt[sel_q] <= cnt[sel_q] - CW'(1);
                res_status <= apqs_pkg::ST_DROPPED;
              end else begin
                res_status <= apqs_pkg::ST_EMPTY;
              end
            end
            apqs_pkg::MODE_REQUEST: begin
              found  <= 1'b0;
              scan   <= '0;
              best_q <= '0;
              best_p <= '0;
              best_w <= '0;
              best_t <= TW'(1);
              state  <= S_SCAN;
            end
            default: begin
              state      <= S_RESP;
              res_status <= apqs_pkg::ST_NONE;
            end
          endcase
        end
        S_SCAN: begin
          if (elig) begin
            state <= S_LOAD;
          end else if (scan_last) begin
            state <= S_DONE;
          end else begin
            scan <= scan + QW'(1);
          end
        end
        S_LOAD: begin
          cur_w <= w_s;
          cur_p <= (w_s < WW'(thr_s)) ? pre_s : post_s;
          cur_t <= (thr_s == '0) ? TW'(1) : thr_s;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          priority if (!found || cur_p > best_p) begin
            found  <= 1'b1;
            best_q <= scan;
            best_p <= cur_p;
            best_w <= cur_w;
            best_t <= cur_t;
            if (scan_last) begin
              state <= S_DONE;
            end else begin
              scan  <= scan + QW'(1);
              state <= S_SCAN;
            end
          end else if (cur_p == best_p) begin
            state <= S_MULA;
          end else begin
            if (scan_last) begin
              state <= S_DONE;
            end else begin
              scan  <= scan + QW'(1);
              state <= S_SCAN;
            end
          end
        end
        S_MULA: begin
          prod_a <= mul_out;
          state  <= S_MULB;
        end
        S_MULB: begin
          prod_b <= mul_out;
          state  <= S_CMP;
        end
        S_CMP: begin
          // greater wait ratio wins a priority tie
          if (prod_a > prod_b) begin
            best_q <= scan;
            best_w <= cur_w;
            best_t <= cur_t;
          end
          if (scan_last) begin
            state <= S_DONE;
          end else begin
            scan  <= scan + QW'(1);
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (found) begin
            head[best_q] <= head_inc;
            cnt[best_q]  <= cnt[best_q] - CW'(1);
            svc_count    <= svc_count + WW'(1);
            res_status   <= apqs_pkg::ST_GRANTED;
            res_q        <= apqs_pkg::QID_W'(best_q);
            res_w        <= best_w;
          end else begin
            res_status <= apqs_pkg::ST_NONE;
            res_q      <= '0;
            res_w      <= '0;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            granted_queue <= res_q;
            waited        <= res_w;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // only a grant advances the service counter
  a_count_on_grant: assert property (@(posedge clk) disable iff (rst)
    (svc_count != $past(svc_count)) |-> ($past(state == S_DONE) && $past(found)))
    else $error("service counter moved without a grant");

  // a result other than a grant carries no queue and no wait
  a_nongrant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != apqs_pkg::ST_GRANTED) |-> (granted_queue == '0 && waited == '0))
    else $error("non-grant result carries queue or wait");

  // the ratio compare only runs after a first candidate was taken
  a_cmp_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULA) |-> found)
    else $error("tie compare without a candidate");

  // an accepted transaction is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");
`endif

endmodule

### dv/aging_priority_queue_scheduler_tb.sv
// self-checking testbench for the aging priority queue scheduler
module aging_priority_queue_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = apqs_pkg::NUM_QUEUES_DEF;
  localparam int DEPTH = apqs_pkg::FIFO_DEPTH_DEF;
  // mode three is not a real operation, the block answers nothing to serve
  localparam logic [apqs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  // cycles with no transaction on either channel before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // margin after the queues drain, before the final verdict
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [apqs_pkg::STATUS_W-1:0] status;
    logic [apqs_pkg::QID_W-1:0]    grant_q;
    logic [apqs_pkg::WAIT_W-1:0]   wait_cnt;
  } outcome_t;

  // predicts each result from its own copy of the registers and fifo state
  class grant_scoreboard;
    bit [apqs_pkg::THR_W-1:0]  thr[NQ];
    bit [apqs_pkg::PRIO_W-1:0] pre_prio[NQ];
    bit [apqs_pkg::PRIO_W-1:0] post_prio[NQ];
    bit [NQ-1:0]               active;
    bit [apqs_pkg::WAIT_W-1:0] svc_count;
    bit [apqs_pkg::WAIT_W-1:0] stamps[NQ][DEPTH];
    int unsigned               head_pos[NQ];
    int unsigned               fill[NQ];
    outcome_t                  pending_outcomes[$];
    int unsigned               faults;

    function new();
      svc_count = '0;
      active = '0;
      faults = 0;
      for (int i = 0; i < NQ; i++) begin
        thr[i] = '0;
        pre_prio[i] = '0;
        post_prio[i] = '0;
        head_pos[i] = 0;
        fill[i] = 0;
      end
    endfunction

    function void write_register(logic [apqs_pkg::CFG_IDX_W-1:0] idx,
                                 logic [apqs_pkg::CFG_DATA_W-1:0] data);
      for (int i = 0; i < NQ; i++) begin
        case (idx)
          apqs_pkg::REG_THRESHOLDS: thr[i] = data[apqs_pkg::THR_W*i +: apqs_pkg::THR_W];
          apqs_pkg::REG_PRE_PRIO:   pre_prio[i] = data[apqs_pkg::PRIO_W*i +: apqs_pkg::PRIO_W];
          apqs_pkg::REG_POST_PRIO:  post_prio[i] = data[apqs_pkg::PRIO_W*i +: apqs_pkg::PRIO_W];
          apqs_pkg::REG_ACTIVE:     active[i] = data[i];
          default: ;
        endcase
      end
    endfunction

    // one scheduler step: updates the state and returns the result it causes
    function outcome_t schedule_step(logic [apqs_pkg::MODE_W-1:0] m,
                                     logic [apqs_pkg::QID_W-1:0] q);
      outcome_t res;
      bit found;
      bit [apqs_pkg::QID_W-1:0] best_q;
      bit [apqs_pkg::PRIO_W-1:0] best_p, pr, po, p;
      bit [apqs_pkg::WAIT_W-1:0] best_w, best_t, w, td;
      bit [63:0] lhs, rhs;
      res.status = apqs_pkg::ST_NONE;
      res.grant_q = '0;
      res.wait_cnt = '0;
      case (m)
        apqs_pkg::MODE_INSERT: begin
          if (fill[q] >= DEPTH) begin
            res.status = apqs_pkg::ST_FULL;
          end else begin
            stamps[q][(head_pos[q] + fill[q]) % DEPTH] = svc_count;
            fill[q]++;
            res.status = apqs_pkg::ST_INSERTED;
          end
        end
        apqs_pkg::MODE_DROP: begin
          if (fill[q] == 0) begin
            res.status = apqs_pkg::ST_EMPTY;
          end else begin
            fill[q]--;
            res.status = apqs_pkg::ST_DROPPED;
          end
        end
        apqs_pkg::MODE_REQUEST: begin
          found = 1'b0;
          best_q = '0;
          best_p = '0;
          best_w = '0;
          best_t = 32'd1;
          for (int i = 0; i < NQ; i++) begin
            if (active[i] && fill[i] != 0) begin
              w = svc_count - stamps[i][head_pos[i]];
              pr = pre_prio[i];
              po = (post_prio[i] < pr) ? pr : post_prio[i];
              p = (w < {16'b0, thr[i]}) ? pr : po;
              td = (thr[i] == 0) ? 32'd1 : {16'b0, thr[i]};
              if (!found || p > best_p) begin
                found = 1'b1;
                best_q = 2'(i);
                best_p = p;
                best_w = w;
                best_t = td;
              end else if (p == best_p) begin
                // exact ratio compare: w/td against best_w/best_t
                lhs = {32'b0, w} * {32'b0, best_t};
                rhs = {32'b0, best_w} * {32'b0, td};
                if (lhs > rhs) begin
                  best_q = 2'(i);
                  best_w = w;
                  best_t = td;
                end
              end
            end
          end
          if (found) begin
            head_pos[best_q] = (head_pos[best_q] + 1) % DEPTH;
            fill[best_q]--;
            svc_count++;
            res.status = apqs_pkg::ST_GRANTED;
            res.grant_q = best_q;
            res.wait_cnt = best_w;
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_transaction(logic [apqs_pkg::MODE_W-1:0] m,
                                   logic [apqs_pkg::QID_W-1:0] q);
      pending_outcomes.insert(pending_outcomes.size(), schedule_step(m, q));
    endfunction

    function void check_result(logic [apqs_pkg::STATUS_W-1:0] st,
                               logic [apqs_pkg::QID_W-1:0] gq,
                               logic [apqs_pkg::WAIT_W-1:0] wt);
      outcome_t exp_res;
      if (pending_outcomes.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result status %0d queue %0d waited %0d",
                   $realtime, st, gq, wt);
      end else begin
        exp_res = pending_outcomes[0];
        pending_outcomes.delete(0);
        if (st !== exp_res.status || gq !== exp_res.grant_q || wt !== exp_res.wait_cnt) begin
          faults++;
          if (faults <= 10)
            $display("%0t: mismatch expected status %0d queue %0d waited %0d, got %0d %0d %0d",
                     $realtime, exp_res.status, exp_res.grant_q, exp_res.wait_cnt,
                     st, gq, wt);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [apqs_pkg::MODE_W-1:0]     mode = apqs_pkg::MODE_INSERT;
  logic [apqs_pkg::QID_W-1:0]      queue_id = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [apqs_pkg::STATUS_W-1:0]   status;
  logic [apqs_pkg::QID_W-1:0]      granted_queue;
  logic [apqs_pkg::WAIT_W-1:0]     waited;
  logic                            cfg_wen = 1'b0;
  logic [apqs_pkg::CFG_IDX_W-1:0]  cfg_index = apqs_pkg::REG_THRESHOLDS;
  logic [apqs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grant_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ins_pct, drop_pct, req_pct;
  logic [apqs_pkg::QID_W-1:0] hot_queue = '0;
  int unsigned quiet_cycles = 0;

  aging_priority_queue_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .queue_id     (queue_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_queue(granted_queue),
    .waited       (waited),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // observe both channels and the config port, and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_wen) sb.write_register(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_result(status, granted_queue, waited);
      if (in_valid && in_ready) sb.note_transaction(mode, queue_id);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("aging_priority_queue_scheduler test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one transaction and hold it until accepted
  task automatic send_item(logic [apqs_pkg::MODE_W-1:0] m, logic [apqs_pkg::QID_W-1:0] q);
    // sender idles in the given share of cycles before offering
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    queue_id <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one register write per cycle; caller lowers the enable afterwards
  task automatic write_reg(logic [apqs_pkg::CFG_IDX_W-1:0] idx,
                           logic [apqs_pkg::CFG_DATA_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_config(logic [63:0] thr_v, logic [31:0] pre_v, logic [31:0] post_v,
                             logic [3:0] act_v);
    write_reg(apqs_pkg::REG_THRESHOLDS, thr_v);
    write_reg(apqs_pkg::REG_PRE_PRIO, {32'b0, pre_v});
    write_reg(apqs_pkg::REG_POST_PRIO, {32'b0, post_v});
    write_reg(apqs_pkg::REG_ACTIVE, {60'b0, act_v});
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // mostly small thresholds so waits cross them, sometimes zero or wide
  function automatic logic [63:0] rand_thresholds();
    logic [63:0] v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(3))
        0: v[16*i +: 16] = 16'd0;
        3: v[16*i +: 16] = 16'($urandom_range(0, 65535));
        default: v[16*i +: 16] = 16'($urandom_range(1, 8));
      endcase
    end
    return v;
  endfunction

  // narrow priority range so ties are common
  function automatic logic [31:0] rand_prios();
    logic [31:0] v;
    for (int i = 0; i < 4; i++)
      v[8*i +: 8] = ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(0, 3));
    return v;
  endfunction

  task automatic send_random(int unsigned n);
    logic [apqs_pkg::MODE_W-1:0] m;
    logic [apqs_pkg::QID_W-1:0] q;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < ins_pct) m = apqs_pkg::MODE_INSERT;
      else if (r < ins_pct + drop_pct) m = apqs_pkg::MODE_DROP;
      else if (r < ins_pct + drop_pct + req_pct) m = apqs_pkg::MODE_REQUEST;
      else m = MODE_UNUSED;
      q = $urandom_range(1) ? hot_queue : 2'($urandom_range(3));
      send_item(m, q);
    end
  endtask

  // drain, reconfigure, then run one batch of random transactions
  task automatic run_phase(logic [63:0] thr_v, logic [31:0] pre_v, logic [31:0] post_v,
                           logic [3:0] act_v, int unsigned ins, int unsigned drp,
                           int unsigned req, int unsigned s_idle, int unsigned r_stall);
    wait_drained();
    load_config(thr_v, pre_v, post_v, act_v);
    ins_pct = ins;
    drop_pct = drp;
    req_pct = req;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    hot_queue = 2'($urandom_range(3));
    send_random(PHASE_ITEMS);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: mixed thresholds incl. zero, one queue with post below pre
    send_idle_pct = 24;
    recv_stall_pct = 72;
    load_config(64'h0003_0000_0002_0001, 32'h05_05_07_05, 32'h09_09_03_09, 4'hf);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);   // nothing queued
    send_item(MODE_UNUSED, 2'd2);              // ignored mode
    send_item(apqs_pkg::MODE_DROP, 2'd3);      // drop from empty
    send_item(apqs_pkg::MODE_INSERT, 2'd0);
    send_item(apqs_pkg::MODE_INSERT, 2'd1);
    send_item(apqs_pkg::MODE_INSERT, 2'd2);
    send_item(apqs_pkg::MODE_INSERT, 2'd3);
    send_item(apqs_pkg::MODE_INSERT, 2'd3);
    send_item(apqs_pkg::MODE_DROP, 2'd3);      // removes newest stamp
    send_item(apqs_pkg::MODE_REQUEST, 2'd3);   // zero threshold goes straight to post
    send_item(apqs_pkg::MODE_REQUEST, 2'd1);
    send_item(apqs_pkg::MODE_INSERT, 2'd0);
    send_item(apqs_pkg::MODE_REQUEST, 2'd2);   // clamped post priority
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);
    send_item(apqs_pkg::MODE_INSERT, 2'd2);
    send_item(apqs_pkg::MODE_INSERT, 2'd1);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);
    send_item(apqs_pkg::MODE_REQUEST, 2'd0);   // drained again
    send_item(MODE_UNUSED, 2'd1);
    in_valid <= 1'b0;

    // all-zero registers: every tie decided by wait ratio then index
    run_phase(64'h0, 32'h0, 32'h0, 4'hf, 45, 10, 40, 24, 72);
    // all-ones registers
    run_phase({64{1'b1}}, {32{1'b1}}, {32{1'b1}}, 4'hf, 50, 10, 35, 24, 72);
    // no queue attached: requests find nothing, queues fill up to full
    run_phase(rand_thresholds(), rand_prios(), rand_prios(), 4'h0, 75, 8, 12, 72, 24);
    run_phase(rand_thresholds(), rand_prios(), rand_prios(), 4'($urandom_range(1, 15)),
              35, 10, 50, 72, 24);
    run_phase(rand_thresholds(), rand_prios(), rand_prios(), 4'hf, 40, 10, 45, 0, 0);
    run_phase(rand_thresholds(), rand_prios(), rand_prios(), 4'($urandom_range(0, 15)),
              45, 10, 40, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0 && sb.outstanding() == 0)
      $display("aging_priority_queue_scheduler test passed");
    else
      $display("aging_priority_queue_scheduler test failed");
    $finish;
  end

endmodule

### files.f
rtl/apqs_pkg.sv
rtl/aging_priority_queue_scheduler.sv
dv/aging_priority_queue_scheduler_tb.sv
